>>> hw/rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: shared definitions for the shortest-arc angle interpolator
// Widths, angle constants, flag bit positions and the per-axis control bundle.
// ----------------------------------------------------------------------------
package spa_pkg;

    // Number format of the angles.
    localparam int ANGLE_FRAC_BITS = 16;

    // Port widths.
    localparam int IN_W   = 32;
    localparam int FRAC_W = ANGLE_FRAC_BITS + 1;
    localparam int FLAG_W = 13;
    localparam int ANG_W  = 10 + ANGLE_FRAC_BITS;

    // Internal widths: reduced angles, differences, products.
    localparam int S_W  = ANG_W + 1;
    localparam int D_W  = S_W + 1;
    localparam int P_W  = D_W + FRAC_W + 1;
    localparam int HI_W = IN_W - ANGLE_FRAC_BITS;
    localparam int R0_W = 10;
    localparam int QP_W = HI_W + 9;

    // Reciprocal of 360 for the integer-degree reduction.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 17;
    localparam int DEG_WHOLE   = 360;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'((longint'(1) << RECIP_SHIFT) / DEG_WHOLE);
    localparam int PROD_W = HI_W + RECIP_W;

    // Angle constants in the fixed-point format.
    localparam longint DEG360_L = longint'(DEG_WHOLE) << ANGLE_FRAC_BITS;
    localparam logic signed [S_W-1:0] DEG360    = S_W'(DEG360_L);
    localparam logic signed [S_W-1:0] DEG180    = S_W'(DEG360_L / 2);
    localparam logic signed [D_W-1:0] DEG720    = D_W'(DEG360_L * 2);
    localparam logic signed [D_W-1:0] ANGLE_MAX = D_W'(DEG360_L * 2 - 1);
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(longint'(1) << ANGLE_FRAC_BITS);
    localparam logic signed [P_W-1:0] ROUND_HALF =
        P_W'(longint'(1) << (ANGLE_FRAC_BITS - 1));

    // Flag word layout: four decision bits per axis and a recorded mark.
    localparam int AXIS_FLAG_W  = 4;
    localparam int FLAG_ADD_S   = 0;
    localparam int FLAG_ADD_E   = 1;
    localparam int FLAG_DOWN_E  = 2;
    localparam int FLAG_DOWN_S  = 3;
    localparam int RECORDED_BIT = 12;

    // Pipeline depth of one axis, and of the whole block from the input register.
    localparam int AXIS_LAT = 11;
    localparam int PIPE_LAT = AXIS_LAT;

    // Control bundle handed to each axis along with its two angles.
    typedef struct packed {
        logic                   decide;
        logic [AXIS_FLAG_W-1:0] frc;
        logic [FRAC_W-1:0]      frac;
    } t_axis_ctl;

endpackage

>>> hw/rtl/spa_axis.sv
// ----------------------------------------------------------------------------
// spa_axis: one axis of the shortest-arc interpolator
// Eleven register stages: reduction modulo 360, arc selection, interpolation
// and final wrap. The pipeline advances every cycle.
// ----------------------------------------------------------------------------
module spa_axis (
    input  logic                          i_clk,
    input  logic [spa_pkg::IN_W-1:0]      i_start_val,
    input  logic [spa_pkg::IN_W-1:0]      i_end_val,
    input  spa_pkg::t_axis_ctl            i_ctl,
    output logic [spa_pkg::ANG_W-1:0]     o_angle,
    output logic [spa_pkg::AXIS_FLAG_W-1:0] o_rec
);
    import spa_pkg::*;

    // Index 0 carries the start angle, index 1 the end angle.
    logic [IN_W-1:0]            r_a_mag  [0:1];
    logic                       r_a_neg  [0:1];
    logic [PROD_W-1:0]          r_b_prod [0:1];
    logic [HI_W-1:0]            r_b_hi   [0:1];
    logic [ANGLE_FRAC_BITS-1:0] r_b_lo   [0:1];
    logic                       r_b_neg  [0:1];
    logic [R0_W-1:0]            r_c_r0   [0:1];
    logic [ANGLE_FRAC_BITS-1:0] r_c_lo   [0:1];
    logic                       r_c_neg  [0:1];
    logic signed [S_W-1:0]      r_d_rem  [0:1];

    t_axis_ctl r_a_ctl, r_b_ctl, r_c_ctl, r_d_ctl, r_e_ctl;

    logic signed [S_W-1:0] r_e_s1, r_e_e1;
    logic                  r_e_add_s, r_e_add_e;
    logic signed [S_W-1:0] r_f_s2, r_f_e2;
    logic [FRAC_W-1:0]     r_f_frac, r_g_frac;
    logic signed [D_W-1:0] r_g_diff;
    logic signed [S_W-1:0] r_g_s, r_h_s;
    logic signed [P_W-1:0] r_h_prod;
    logic signed [D_W-1:0] r_i_rnd, r_i_s, r_i_s360;
    logic signed [D_W-1:0] r_j_r, r_j_r360;
    logic [ANG_W-1:0]      r_k_angle;
    logic [AXIS_FLAG_W-1:0] r_f_rec, r_g_rec, r_h_rec, r_i_rec, r_j_rec, r_k_rec;

    logic [HI_W-1:0]        n_c_q   [0:1];
    logic [QP_W-1:0]        n_c_qx  [0:1];
    logic [R0_W-1:0]        n_d_r   [0:1];
    logic [ANG_W-2:0]       n_d_mag [0:1];
    logic                   n_e_add_s, n_e_add_e;
    logic signed [D_W-1:0]  n_f_diff;
    logic                   n_f_down_e, n_f_down_s;
    logic signed [P_W-1:0]  n_i_rnd;

    // Stage A: sign and magnitude of both endpoints.
    always_ff @(posedge i_clk) begin
        r_a_neg[0] <= i_start_val[IN_W-1];
        r_a_neg[1] <= i_end_val[IN_W-1];
        r_a_mag[0] <= i_start_val[IN_W-1] ? IN_W'(-i_start_val) : i_start_val;
        r_a_mag[1] <= i_end_val[IN_W-1] ? IN_W'(-i_end_val) : i_end_val;
        r_a_ctl    <= i_ctl;
    end

    // Stage B: whole degrees times the reciprocal of 360.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_b_hi[k]   <= r_a_mag[k][IN_W-1:ANGLE_FRAC_BITS];
            r_b_lo[k]   <= r_a_mag[k][ANGLE_FRAC_BITS-1:0];
            r_b_neg[k]  <= r_a_neg[k];
            r_b_prod[k] <= PROD_W'(r_a_mag[k][IN_W-1:ANGLE_FRAC_BITS]) * PROD_W'(RECIP_M);
        end
        r_b_ctl <= r_a_ctl;
    end

    // Stage C: first remainder estimate, at most one 360 too large.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_c_q[k]  = HI_W'(r_b_prod[k] >> RECIP_SHIFT);
            n_c_qx[k] = QP_W'(n_c_q[k]) * QP_W'(DEG_WHOLE);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_c_r0[k]  <= R0_W'(QP_W'(r_b_hi[k]) - n_c_qx[k]);
            r_c_lo[k]  <= r_b_lo[k];
            r_c_neg[k] <= r_b_neg[k];
        end
        r_c_ctl <= r_b_ctl;
    end

    // Stage D: correct the remainder and give it the sign of the dividend.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_d_r[k] = (r_c_r0[k] >= R0_W'(DEG_WHOLE)) ?
                       r_c_r0[k] - R0_W'(DEG_WHOLE) : r_c_r0[k];
            n_d_mag[k] = {n_d_r[k][R0_W-2:0], r_c_lo[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_d_rem[k] <= r_c_neg[k] ? -S_W'(n_d_mag[k]) : S_W'(n_d_mag[k]);
        end
        r_d_ctl <= r_c_ctl;
    end

    // Stage E: lift endpoints by 360 where forced, or negative ones when deciding.
    always_comb begin
        n_e_add_s = r_d_ctl.frc[FLAG_ADD_S] | (r_d_ctl.decide & r_d_rem[0][S_W-1]);
        n_e_add_e = r_d_ctl.frc[FLAG_ADD_E] | (r_d_ctl.decide & r_d_rem[1][S_W-1]);
    end

    always_ff @(posedge i_clk) begin
        r_e_s1    <= r_d_rem[0] + (n_e_add_s ? DEG360 : S_W'(0));
        r_e_e1    <= r_d_rem[1] + (n_e_add_e ? DEG360 : S_W'(0));
        r_e_add_s <= n_e_add_s;
        r_e_add_e <= n_e_add_e;
        r_e_ctl   <= r_d_ctl;
    end

    // Stage F: pick the shorter arc; end-down wins over start-down.
    always_comb begin
        n_f_diff   = D_W'(r_e_e1) - D_W'(r_e_s1);
        n_f_down_e = r_e_ctl.frc[FLAG_DOWN_E] |
                     (r_e_ctl.decide & (n_f_diff > D_W'(DEG180)));
        n_f_down_s = !n_f_down_e & (r_e_ctl.frc[FLAG_DOWN_S] |
                     (r_e_ctl.decide & (n_f_diff < -D_W'(DEG180))));
    end

    // The recorded bits follow the flag layout: down start, down end, add end, add start.
    always_ff @(posedge i_clk) begin
        r_f_s2   <= n_f_down_s ? r_e_s1 - DEG360 : r_e_s1;
        r_f_e2   <= n_f_down_e ? r_e_e1 - DEG360 : r_e_e1;
        r_f_frac <= r_e_ctl.frac;
        r_f_rec  <= {n_f_down_s, n_f_down_e, r_e_add_e, r_e_add_s};
    end

    // Stage G: span of the path.
    always_ff @(posedge i_clk) begin
        r_g_diff <= D_W'(r_f_e2) - D_W'(r_f_s2);
        r_g_s    <= r_f_s2;
        r_g_frac <= r_f_frac;
        r_g_rec  <= r_f_rec;
    end

    // Stage H: span times fraction.
    always_ff @(posedge i_clk) begin
        r_h_prod <= r_g_diff * $signed({1'b0, r_g_frac});
        r_h_s    <= r_g_s;
        r_h_rec  <= r_g_rec;
    end

    // Stage I: round to nearest unit, halves upward; prepare start plus 360.
    assign n_i_rnd = (r_h_prod + ROUND_HALF) >>> ANGLE_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_i_rnd  <= D_W'(n_i_rnd);
        r_i_s    <= D_W'(r_h_s);
        r_i_s360 <= D_W'(r_h_s) + D_W'(DEG360);
        r_i_rec  <= r_h_rec;
    end

    // Stage J: interpolated angle, plain and wrapped by 360.
    always_ff @(posedge i_clk) begin
        r_j_r    <= r_i_s + r_i_rnd;
        r_j_r360 <= r_i_s360 + r_i_rnd;
        r_j_rec  <= r_i_rec;
    end

    // Stage K: wrap negative results and clamp to the output range.
    always_ff @(posedge i_clk) begin
        if (r_j_r[D_W-1]) begin
            r_k_angle <= r_j_r360[D_W-1] ? '0 : ANG_W'(r_j_r360);
        end else if (r_j_r >= DEG720) begin
            r_k_angle <= ANG_W'(ANGLE_MAX);
        end else begin
            r_k_angle <= ANG_W'(r_j_r);
        end
        r_k_rec <= r_j_rec;
    end

    assign o_angle = r_k_angle;
    assign o_rec   = r_k_rec;

endmodule

>>> hw/rtl/shortest_path_angle_lerp_core.sv
// ----------------------------------------------------------------------------
// shortest_path_angle_lerp_core: shortest-arc interpolation of three angles
// Interpolates three Q16.16 degree angles along the shorter arc and reports
// the per-axis path decisions in a flag word.
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle in which start is high; busy never
// rises. Each result appears on the o_ ports for one cycle with o_valid high,
// in order of start, after one input register and then the eleven-stage
// axis pipeline (remainder by 360 through a reciprocal multiply, arc choice,
// the span-times-fraction multiply, rounding and wrap).
// The results must be captured when o_valid is high; there is no hold-off.
module shortest_path_angle_lerp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [spa_pkg::IN_W-1:0]       i_start_x,
    input  logic [spa_pkg::IN_W-1:0]       i_start_y,
    input  logic [spa_pkg::IN_W-1:0]       i_start_z,
    input  logic [spa_pkg::IN_W-1:0]       i_end_x,
    input  logic [spa_pkg::IN_W-1:0]       i_end_y,
    input  logic [spa_pkg::IN_W-1:0]       i_end_z,
    input  logic [spa_pkg::FRAC_W-1:0]     i_fraction,
    input  logic [spa_pkg::FLAG_W-1:0]     i_path_flags_in,
    output logic                           o_valid,
    output logic [spa_pkg::ANG_W-1:0]      o_angle_x,
    output logic [spa_pkg::ANG_W-1:0]      o_angle_y,
    output logic [spa_pkg::ANG_W-1:0]      o_angle_z,
    output logic [spa_pkg::FLAG_W-1:0]     o_path_flags_out
);
    import spa_pkg::*;

    logic [IN_W-1:0]   r_in_start [0:2];
    logic [IN_W-1:0]   r_in_end   [0:2];
    logic [FRAC_W-1:0] r_in_frac;
    logic [FLAG_W-1:0] r_flg [0:PIPE_LAT];
    logic [PIPE_LAT:0] r_vld;

    logic              n_accept;
    t_axis_ctl         n_ctl [0:2];
    logic [ANG_W-1:0]  n_angle [0:2];
    logic [AXIS_FLAG_W-1:0] n_rec [0:2];

    // The pipeline never stalls, so every start is a transaction.
    assign busy     = 1'b0;
    assign n_accept = start & !busy;

    // Input register; the fraction saturates at one.
    always_ff @(posedge i_clk) begin
        r_in_start[0] <= i_start_x;
        r_in_start[1] <= i_start_y;
        r_in_start[2] <= i_start_z;
        r_in_end[0]   <= i_end_x;
        r_in_end[1]   <= i_end_y;
        r_in_end[2]   <= i_end_z;
        r_in_frac     <= (i_fraction > FRAC_ONE) ? FRAC_ONE : i_fraction;
        r_flg[0]      <= i_path_flags_in;
        for (int k = 1; k <= PIPE_LAT; k++) begin
            r_flg[k] <= r_flg[k-1];
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-1:0], n_accept};
        end
    end

    // Per-axis control: forced decision bits, or decide when the word is zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ctl[k].decide = (r_flg[0] == '0);
            n_ctl[k].frc    = r_flg[0][k*AXIS_FLAG_W +: AXIS_FLAG_W];
            n_ctl[k].frac   = r_in_frac;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_axis
        spa_axis u_axis (
            .i_clk       (i_clk),
            .i_start_val (r_in_start[g]),
            .i_end_val   (r_in_end[g]),
            .i_ctl       (n_ctl[g]),
            .o_angle     (n_angle[g]),
            .o_rec       (n_rec[g])
        );
    end

    // Result: forced flags come back unchanged, decided ones get the mark.
    assign o_valid          = r_vld[PIPE_LAT];
    assign o_angle_x        = n_angle[0];
    assign o_angle_y        = n_angle[1];
    assign o_angle_z        = n_angle[2];
    assign o_path_flags_out = (r_flg[PIPE_LAT] != '0) ? r_flg[PIPE_LAT] :
                              {1'b1, n_rec[2], n_rec[1], n_rec[0]};

endmodule
